FILE: design/strict_base64url_decoder_macros.svh
// Assertion macros for the strict base64url decoder.
`ifndef STRICT_BASE64URL_DECODER_MACROS_SVH
`define STRICT_BASE64URL_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SB64U_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SB64U_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sb64u_pkg.sv
// Shared constants, types and the alphabet decode of the base64url decoder.
package sb64u_pkg;

   localparam int MAX_STRING_CHARS_DEFAULT = 65535;

   localparam logic [15:0] CHAR_LIMIT_RESET      = 16'd65535;
   localparam logic [15:0] OUTPUT_CAPACITY_RESET = 16'd49152;

   // Register indexes on the csr port
   localparam logic CSR_CHAR_LIMIT      = 1'b0;
   localparam logic CSR_OUTPUT_CAPACITY = 1'b1;

   // Position of a character within its group of four
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;
   localparam logic [1:0] PHASE_FOURTH = 2'd3;

   // Character counter saturates here
   localparam logic [16:0] CHARS_SAT = 17'h1FFFF;

   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHR_MINUS   = 8'h2D;
   localparam logic [7:0] CHR_USCORE  = 8'h5F;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Alphabet lookup; anything outside it (padding included) decodes to 0, not ok.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] d;
      r = '{ok: 1'b0, value: 6'd0};
      d = 8'd0;
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
         d = c - CHR_UPPER_A;
         r = '{ok: 1'b1, value: d[5:0]};
      end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
         d = c - CHR_LOWER_A + 8'd26;
         r = '{ok: 1'b1, value: d[5:0]};
      end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
         d = c - CHR_DIGIT_0 + 8'd52;
         r = '{ok: 1'b1, value: d[5:0]};
      end else if (c == CHR_MINUS) begin
         r = '{ok: 1'b1, value: 6'd62};
      end else if (c == CHR_USCORE) begin
         r = '{ok: 1'b1, value: 6'd63};
      end
      return r;
   endfunction

endpackage

FILE: design/strict_base64url_decoder.sv
// Strict unpadded base64url decoder, one character item in, at most one byte item out.
//
// Characters of a string enter on req_ (tlast marks the final character), one per cycle
// while req_tready is high. Each item passes an input register and then one short
// decode-and-shift step into the result register, so the block sustains one character per
// cycle while rsp_tready is high. The only limit is the single result register: while a
// result waits with rsp_tready low, one more character can enter the input register, and
// after that the input stalls. Characters 2, 3 and 4 of each group of four each
// yield one byte item; the final character always yields an item with tlast set, which
// carries the status (tuser[1], 1 = malformed) and, when accepted, the byte total. The
// string is malformed on a character outside A-Z a-z 0-9 - _, a length of 1 mod 4, a
// length above min(char_limit, MAX_STRING_CHARS), ceil(len/4)*3 above output_capacity,
// or nonzero unused low bits in the final partial group. After the first error no more
// byte items are sent; the consumer drops the bytes of a string ending in error.
// Configuration is written through csr_ and takes effect at once.
`include "strict_base64url_decoder_macros.svh"

module strict_base64url_decoder #(
   parameter int MAX_STRING_CHARS = sb64u_pkg::MAX_STRING_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   // decoded output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [23:8] byte_count
   output logic [1:0]  rsp_tuser,   // [0] data_valid, [1] status
   output logic        rsp_tlast,   // end_of_string
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [15:0] MAX_LIMIT = 16'(MAX_STRING_CHARS);

   // configuration registers
   logic [15:0] char_limit_ff, output_capacity_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;

   // string state (group_bits never holds more than six live bits)
   logic [5:0]  group_bits_ff, group_bits_in;
   logic [1:0]  group_phase_ff, group_phase_in;
   logic [16:0] chars_seen_ff, chars_seen_in;
   logic [15:0] bytes_out_ff, bytes_out_in;
   logic        error_seen_ff, error_seen_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic        data_valid_ff, data_valid_in;
   logic        eos_ff, eos_in;
   logic        status_ff, status_in;
   logic [15:0] byte_count_ff, byte_count_in;

   logic                  out_free, process;
   sb64u_pkg::sextet_type sx;
   logic [15:0]           limit;
   logic [16:0]           count;
   logic [17:0]           count_p3;
   logic [17:0]           need_bytes;
   logic                  fault;
   logic [11:0]           acc;
   logic                  emit;
   logic [7:0]            byte_val;
   logic [5:0]            bits_next;

   // The result slot is free when empty or being taken this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign process    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tready && req_tvalid) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_limit_ff      <= sb64u_pkg::CHAR_LIMIT_RESET;
         output_capacity_ff <= sb64u_pkg::OUTPUT_CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sb64u_pkg::CSR_CHAR_LIMIT:      char_limit_ff      <= csr_wdata;
            sb64u_pkg::CSR_OUTPUT_CAPACITY: output_capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode of the held character against the string state.
   always_comb begin
      sx       = sb64u_pkg::sextet_of(s1_char_ff);
      limit    = (char_limit_ff < MAX_LIMIT) ? char_limit_ff : MAX_LIMIT;
      count    = (chars_seen_ff < sb64u_pkg::CHARS_SAT) ? chars_seen_ff + 17'd1
                                                        : sb64u_pkg::CHARS_SAT;
      count_p3 = {1'b0, count} + 18'd3;
      // groups begun so far, this one included, times three bytes
      need_bytes = {1'b0, count_p3[17:2], 1'b0} + {2'b00, count_p3[17:2]};

      fault = !sx.ok || ({1'b0, limit} < count);
      if (group_phase_ff == sb64u_pkg::PHASE_FIRST &&
          need_bytes > {2'b00, output_capacity_ff}) begin
         fault = 1'b1;
      end
      if (s1_last_ff) begin
         // length 1 mod 4, or nonzero padding bits in a partial group
         case (group_phase_ff)
            sb64u_pkg::PHASE_FIRST:  fault = 1'b1;
            sb64u_pkg::PHASE_SECOND: if (sx.value[3:0] != 4'd0) fault = 1'b1;
            sb64u_pkg::PHASE_THIRD:  if (sx.value[1:0] != 2'd0) fault = 1'b1;
            default: ;
         endcase
      end
      error_seen_in = error_seen_ff || fault;

      acc       = {group_bits_ff, sx.value};
      emit      = 1'b0;
      byte_val  = 8'd0;
      bits_next = group_bits_ff;
      if (!error_seen_in) begin
         case (group_phase_ff)
            sb64u_pkg::PHASE_FIRST: begin
               bits_next = sx.value;
            end
            sb64u_pkg::PHASE_SECOND: begin
               byte_val  = acc[11:4];
               bits_next = {2'b00, acc[3:0]};
               emit      = 1'b1;
            end
            sb64u_pkg::PHASE_THIRD: begin
               byte_val  = acc[9:2];
               bits_next = {4'd0, acc[1:0]};
               emit      = 1'b1;
            end
            default: begin
               byte_val  = acc[7:0];
               bits_next = 6'd0;
               emit      = 1'b1;
            end
         endcase
      end
      bytes_out_in = emit ? bytes_out_ff + 16'd1 : bytes_out_ff;

      // the final character clears the string state
      if (s1_last_ff) begin
         group_bits_in  = 6'd0;
         group_phase_in = sb64u_pkg::PHASE_FIRST;
         chars_seen_in  = 17'd0;
      end else begin
         group_bits_in  = bits_next;
         group_phase_in = group_phase_ff + 2'd1;
         chars_seen_in  = count;
      end

      data_byte_in  = byte_val;
      data_valid_in = emit;
      eos_in        = s1_last_ff;
      status_in     = s1_last_ff && error_seen_in;
      byte_count_in = (s1_last_ff && !error_seen_in) ? bytes_out_in : 16'd0;

      if (process && (emit || s1_last_ff)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff  <= 6'd0;
         group_phase_ff <= sb64u_pkg::PHASE_FIRST;
         chars_seen_ff  <= 17'd0;
         bytes_out_ff   <= 16'd0;
         error_seen_ff  <= 1'b0;
      end else if (process) begin
         group_bits_ff  <= group_bits_in;
         group_phase_ff <= group_phase_in;
         chars_seen_ff  <= chars_seen_in;
         bytes_out_ff   <= s1_last_ff ? 16'd0 : bytes_out_in;
         error_seen_ff  <= s1_last_ff ? 1'b0 : error_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (process && (emit || s1_last_ff)) begin
         data_byte_ff  <= data_byte_in;
         data_valid_ff <= data_valid_in;
         eos_ff        <= eos_in;
         status_ff     <= status_in;
         byte_count_ff <= byte_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {byte_count_ff, data_byte_ff};
   assign rsp_tuser  = {status_ff, data_valid_ff};
   assign rsp_tlast  = eos_ff;

   // Only the final item of a string may come without a byte.
   `SB64U_ASSERT_NOW(a_byteless_is_final, clock, reset,
      rsp_valid_ff && !data_valid_ff, eos_ff, "byteless result that is not final")
   // A malformed string reports no byte and a zero total.
   `SB64U_ASSERT_NOW(a_error_clean, clock, reset,
      rsp_valid_ff && status_ff,
      eos_ff && !data_valid_ff && (byte_count_ff == 16'd0), "malformed result not clean")
   // The final character leaves the string state cleared.
   `SB64U_ASSERT_NEXT(a_state_cleared, clock, reset,
      process && s1_last_ff,
      (chars_seen_ff == 17'd0) && (group_phase_ff == sb64u_pkg::PHASE_FIRST) &&
      !error_seen_ff && (bytes_out_ff == 16'd0), "string state not cleared")

endmodule

FILE: tb/strict_base64url_decoder_tb.sv
// Self-checking testbench for the strict base64url decoder: directed and random strings.
`timescale 1ns / 1ps

module strict_base64url_decoder_tb;

   localparam int MAX_CHARS    = sb64u_pkg::MAX_STRING_CHARS_DEFAULT;
   localparam int RANDOM_ITEMS = 450;

   // One result item as the decoder should emit it
   typedef struct {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        end_of_string;
      logic        status;
      logic [15:0] byte_count;
   } decoded_item_type;

   // Tracks decoder state per string and holds the results still owed by the block.
   class decode_scoreboard_type;
      int unsigned max_chars;
      logic [15:0] char_limit;
      logic [15:0] output_capacity;
      logic [17:0] group_bits;
      logic [1:0]  group_phase;
      logic [16:0] chars_seen;
      logic [15:0] bytes_out;
      logic        error_seen;
      decoded_item_type owed_results[$];
      int errors;
      int results_checked;
      int strings_done;
      int strings_malformed;

      function new(int unsigned max_chars_i);
         max_chars = max_chars_i;
         char_limit = sb64u_pkg::CHAR_LIMIT_RESET;
         output_capacity = sb64u_pkg::OUTPUT_CAPACITY_RESET;
         errors = 0;
         results_checked = 0;
         strings_done = 0;
         strings_malformed = 0;
         restart_string();
      endfunction

      function void restart_string();
         group_bits = '0;
         group_phase = sb64u_pkg::PHASE_FIRST;
         chars_seen = '0;
         bytes_out = '0;
         error_seen = 1'b0;
      endfunction

      function void set_reg(logic idx, logic [15:0] val);
         if (idx == sb64u_pkg::CSR_CHAR_LIMIT) char_limit = val;
         else if (idx == sb64u_pkg::CSR_OUTPUT_CAPACITY) output_capacity = val;
      endfunction

      // Sextet value of one character; ok is low outside the url-safe alphabet.
      function void char_value(input logic [7:0] c, output logic ok, output logic [5:0] v);
         ok = 1'b1;
         v = '0;
         if (c inside {[sb64u_pkg::CHR_UPPER_A:sb64u_pkg::CHR_UPPER_Z]})
            v = 6'(c - sb64u_pkg::CHR_UPPER_A);
         else if (c inside {[sb64u_pkg::CHR_LOWER_A:sb64u_pkg::CHR_LOWER_Z]})
            v = 6'(c - sb64u_pkg::CHR_LOWER_A + 8'd26);
         else if (c inside {[sb64u_pkg::CHR_DIGIT_0:sb64u_pkg::CHR_DIGIT_9]})
            v = 6'(c - sb64u_pkg::CHR_DIGIT_0 + 8'd52);
         else if (c == sb64u_pkg::CHR_MINUS) v = 6'd62;
         else if (c == sb64u_pkg::CHR_USCORE) v = 6'd63;
         else ok = 1'b0;
      endfunction

      function void note_char(logic [7:0] c, logic last);
         logic ok;
         logic [5:0] v;
         logic [1:0] ph;
         logic [16:0] cnt;
         logic [17:0] acc;
         logic emit;
         logic [7:0] b;
         int unsigned lim;
         int unsigned need;
         decoded_item_type r;
         char_value(c, ok, v);
         ph = group_phase;
         lim = (int'(char_limit) < max_chars) ? char_limit : max_chars;
         cnt = (chars_seen < sb64u_pkg::CHARS_SAT) ? chars_seen + 17'd1 : sb64u_pkg::CHARS_SAT;
         need = ((int'(cnt) + 3) / 4) * 3;
         emit = 1'b0;
         b = '0;
         if (!ok) error_seen = 1'b1;
         if (cnt > lim) error_seen = 1'b1;
         if (ph == sb64u_pkg::PHASE_FIRST && need > output_capacity) error_seen = 1'b1;
         if (last) begin
            // a string may not stop on a group boundary plus one, nor leave stray low bits
            if (ph == sb64u_pkg::PHASE_FIRST) error_seen = 1'b1;
            else if (ph == sb64u_pkg::PHASE_SECOND && v[3:0] != 4'd0) error_seen = 1'b1;
            else if (ph == sb64u_pkg::PHASE_THIRD && v[1:0] != 2'd0) error_seen = 1'b1;
         end
         if (!error_seen) begin
            acc = {group_bits[11:0], v};
            case (ph)
               sb64u_pkg::PHASE_FIRST: begin
                  group_bits = {12'd0, acc[5:0]};
               end
               sb64u_pkg::PHASE_SECOND: begin
                  b = acc[11:4];
                  group_bits = {14'd0, acc[3:0]};
                  emit = 1'b1;
               end
               sb64u_pkg::PHASE_THIRD: begin
                  b = acc[9:2];
                  group_bits = {16'd0, acc[1:0]};
                  emit = 1'b1;
               end
               default: begin
                  b = acc[7:0];
                  group_bits = '0;
                  emit = 1'b1;
               end
            endcase
            if (emit) bytes_out = bytes_out + 16'd1;
         end
         group_phase = ph + 2'd1;
         chars_seen = cnt;
         if (last) begin
            r.data_byte = emit ? b : 8'd0;
            r.data_valid = emit;
            r.end_of_string = 1'b1;
            r.status = error_seen;
            r.byte_count = error_seen ? 16'd0 : bytes_out;
            owed_results.push_back(r);
            strings_done++;
            if (error_seen) strings_malformed++;
            restart_string();
         end else if (emit) begin
            r.data_byte = b;
            r.data_valid = 1'b1;
            r.end_of_string = 1'b0;
            r.status = 1'b0;
            r.byte_count = 16'd0;
            owed_results.push_back(r);
         end
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [7:0] db, logic dv, logic eos, logic st,
                                 logic [15:0] bc);
         decoded_item_type w;
         if (owed_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual byte %0h tlast %0b",
                     $time, db, eos);
            errors++;
            return;
         end
         w = owed_results.pop_front();
         results_checked++;
         compare_field("data_byte", 16'(w.data_byte), 16'(db));
         compare_field("data_valid", 16'(w.data_valid), 16'(dv));
         compare_field("end_of_string", 16'(w.end_of_string), 16'(eos));
         compare_field("status", 16'(w.status), 16'(st));
         compare_field("byte_count", w.byte_count, bc);
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      function void flush_leftover();
         if (owed_results.size() != 0) begin
            $display("%0t ns: %0d result items never arrived, expected 0 outstanding",
                     $time, owed_results.size());
            errors += owed_results.size();
         end
      endfunction
   endclass

   // Clock, reset and every block input start at known values
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = sb64u_pkg::CSR_CHAR_LIMIT;
   logic [15:0] csr_wdata = 16'd0;

   decode_scoreboard_type sb = new(MAX_CHARS);

   int items_sent = 0;
   int burst_left = 0;
   int csr_writes = 0;
   int ready_run = 0;
   int ready_mode = 0;

   strict_base64url_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Hard stop well beyond the slowest legal run
   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random-length runs in one of four moods - always ready, mostly ready,
   // coin toss, or ready only when the run counter is a multiple of five.
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_run = $urandom_range(4, 40);
      end
      ready_run--;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (ready_run % 5 == 0);
      endcase
   end

   // Both handshakes are sampled at the rising edge; results are checked before the
   // item of the same edge is noted, though a result never follows its item that soon.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tuser[1],
                            rsp_tdata[23:8]);
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
      end
   end

   // Called and left at a falling edge. The sender works in bursts; between bursts
   // tvalid drops for a random gap, and about a quarter of bursts follow with no gap.
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tdata = c;
      req_tlast = last;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Only between strings: every item still owed must come back, and the two-stage pipe
   // must drain, before the next register write.
   task automatic settle();
      int waited;
      waited = 0;
      req_tvalid = 1'b0;
      while (sb.outstanding() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.set_reg(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_limits(input logic [15:0] limit, input logic [15:0] capacity);
      write_reg(sb64u_pkg::CSR_CHAR_LIMIT, limit);
      write_reg(sb64u_pkg::CSR_OUTPUT_CAPACITY, capacity);
   endtask

   // Encoder side of the alphabet, used to build well-formed strings
   function automatic logic [7:0] alpha_char(input logic [5:0] v);
      if (v < 6'd26) return sb64u_pkg::CHR_UPPER_A + 8'(v);
      if (v < 6'd52) return sb64u_pkg::CHR_LOWER_A + 8'(v - 6'd26);
      if (v < 6'd62) return sb64u_pkg::CHR_DIGIT_0 + 8'(v - 6'd52);
      if (v == 6'd62) return sb64u_pkg::CHR_MINUS;
      return sb64u_pkg::CHR_USCORE;
   endfunction

   // Most strings are well formed with canonical tails; the rest are ragged tails,
   // raw byte noise, or a good string with one character spoiled.
   task automatic send_random_string();
      logic [7:0] text[$];
      logic [5:0] v;
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      len = $urandom_range(2, 22);
      if (kind == 7) len = $urandom_range(1, 13);
      if (kind != 7 && len % 4 == 1) len++;
      if (kind == 8) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         for (int i = 0; i < len; i++) begin
            v = 6'($urandom);
            if (kind != 7 && i == len - 1) begin
               // clear the bits a short tail cannot carry
               if (len % 4 == 2) v[3:0] = 4'd0;
               else if (len % 4 == 3) v[1:0] = 2'd0;
            end
            text.push_back(alpha_char(v));
         end
         if (kind == 9)
            text[$urandom_range(0, len - 1)] = ($urandom_range(0, 2) == 0) ?
               8'h3D : 8'($urandom_range(0, 255));
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   initial begin
      int phase_end;
      int directed_items;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      // Directed: whole alphabet edges, padding, raw extremes, short tails good and bad
      send_text("AZaz09-_");
      send_text("=");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      send_text("QQ");
      send_text("QR");
      send_text("QUF");
      settle();
      // zero length limit rejects everything
      set_limits(16'd0, sb64u_pkg::OUTPUT_CAPACITY_RESET);
      send_text("AA");
      settle();
      // length fault on the final character swallows its byte
      set_limits(16'd3, sb64u_pkg::OUTPUT_CAPACITY_RESET);
      send_text("AAAA");
      settle();
      // capacity fault at the first character of a group
      set_limits(16'hFFFF, 16'd2);
      send_text("AA");
      settle();
      set_limits(sb64u_pkg::CHAR_LIMIT_RESET, sb64u_pkg::OUTPUT_CAPACITY_RESET);
      directed_items = items_sent;

      // Random phases, each under its own register setting
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: set_limits(16'hFFFF, 16'd49152);
            1: set_limits(16'($urandom_range(1, 24)), 16'd49152);
            2: set_limits(16'hFFFF, 16'($urandom_range(0, 18)));
            3: set_limits(16'($urandom_range(1, 24)), 16'($urandom_range(0, 18)));
            4: set_limits($urandom_range(0, 1) ? 16'd1 : 16'd0,
                          $urandom_range(0, 1) ? 16'd49152 : 16'd0);
            default: set_limits(16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 49152)));
         endcase
         phase_end = items_sent + $urandom_range(30, 70);
         while (items_sent < phase_end) send_random_string();
         settle();
      end

      repeat (10) @(negedge clock);
      sb.flush_leftover();
      $display("Covered %0d characters in %0d strings (%0d malformed), %0d register writes.",
               items_sent, sb.strings_done, sb.strings_malformed, csr_writes);
      $display("Checked %0d result items with %0d mismatches.", sb.results_checked,
               sb.errors);
      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
